@@ hw/rtl/lcd4_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// lcd4_pkg
// Types, constants and the power-up init table shared by the character LCD
// 4-bit nibble sequencer.
// ----------------------------------------------------------------------------
package lcd4_pkg;

  localparam int unsigned QUEUE_DEPTH = 2;

  localparam int unsigned NIB_W    = 4;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned BEFORE_W = 15;
  localparam int unsigned AFTER_W  = 13;
  localparam int unsigned STEP_W   = 4;

  typedef enum logic [1:0] {
    REQ_INIT     = 2'd0,
    REQ_WRITE    = 2'd1,
    REQ_SET_LINE = 2'd2,
    REQ_CLEAR    = 2'd3
  } req_type_e;

  localparam logic [BYTE_W-1:0]   CMD_TOP_LINE    = 8'h80;
  localparam logic [BYTE_W-1:0]   CMD_BOTTOM_LINE = 8'hC0;
  localparam logic [BYTE_W-1:0]   CMD_CLEAR       = 8'h01;
  localparam logic [BYTE_W-1:0]   CMD_FUNC_SET    = 8'h28;
  localparam logic [BYTE_W-1:0]   CMD_DISP_OFF    = 8'h08;
  localparam logic [BYTE_W-1:0]   CMD_ENTRY_MODE  = 8'h06;
  localparam logic [BYTE_W-1:0]   CMD_DISP_ON     = 8'h0E;
  localparam logic [NIB_W-1:0]    NIB_WAKE        = 4'h3;
  localparam logic [NIB_W-1:0]    NIB_4BIT        = 4'h2;

  localparam logic [BEFORE_W-1:0] POWERUP_WAIT_US = 15'd20000;
  localparam logic [AFTER_W-1:0]  HI_GAP_US       = 13'd15;
  localparam logic [AFTER_W-1:0]  LO_GAP_US       = 13'd55;
  localparam logic [AFTER_W-1:0]  LO_GAP_EXTRA_US = 13'd105;
  localparam logic [AFTER_W-1:0]  CLEAR_GAP_US    = 13'd5055;
  localparam logic [AFTER_W-1:0]  WAKE0_GAP_US    = 13'd5005;
  localparam logic [AFTER_W-1:0]  WAKE1_GAP_US    = 13'd205;

  localparam logic [STEP_W-1:0]   INIT_LAST_STEP  = 4'd13;
  localparam logic [STEP_W-1:0]   BYTE_LAST_STEP  = 4'd1;

  // one queued job for the back end
  typedef struct packed {
    logic                is_init;
    logic                rs;
    logic [BYTE_W-1:0]   cmd_byte;
    logic [AFTER_W-1:0]  low_after;
  } desc_t;

  typedef struct packed {
    logic [NIB_W-1:0]    nib;
    logic [BEFORE_W-1:0] pre_wait;
    logic [AFTER_W-1:0]  after;
  } nib_xfer_t;

  function automatic nib_xfer_t init_step(input logic [STEP_W-1:0] step);
    nib_xfer_t x;
    x.pre_wait = '0;
    case (step)
      4'd0: begin
        x.nib      = NIB_WAKE;
        x.pre_wait = POWERUP_WAIT_US;
        x.after    = WAKE0_GAP_US;
      end
      4'd1: begin
        x.nib   = NIB_WAKE;
        x.after = WAKE1_GAP_US;
      end
      4'd2: begin
        x.nib   = NIB_WAKE;
        x.after = LO_GAP_US;
      end
      4'd3: begin
        x.nib   = NIB_4BIT;
        x.after = LO_GAP_US;
      end
      4'd4: begin
        x.nib   = CMD_FUNC_SET[7:4];
        x.after = HI_GAP_US;
      end
      4'd5: begin
        x.nib   = CMD_FUNC_SET[3:0];
        x.after = LO_GAP_EXTRA_US;
      end
      4'd6: begin
        x.nib   = CMD_DISP_OFF[7:4];
        x.after = HI_GAP_US;
      end
      4'd7: begin
        x.nib   = CMD_DISP_OFF[3:0];
        x.after = LO_GAP_EXTRA_US;
      end
      4'd8: begin
        x.nib   = CMD_CLEAR[7:4];
        x.after = HI_GAP_US;
      end
      4'd9: begin
        x.nib   = CMD_CLEAR[3:0];
        x.after = CLEAR_GAP_US;
      end
      4'd10: begin
        x.nib   = CMD_ENTRY_MODE[7:4];
        x.after = HI_GAP_US;
      end
      4'd11: begin
        x.nib   = CMD_ENTRY_MODE[3:0];
        x.after = LO_GAP_EXTRA_US;
      end
      4'd12: begin
        x.nib   = CMD_DISP_ON[7:4];
        x.after = HI_GAP_US;
      end
      4'd13: begin
        x.nib   = CMD_DISP_ON[3:0];
        x.after = LO_GAP_EXTRA_US;
      end
      default: begin
        x.nib   = '0;
        x.after = '0;
      end
    endcase
    return x;
  endfunction

endpackage
`default_nettype wire

@@ hw/rtl/lcd4_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// lcd4 channel interfaces
// Request channel into the sequencer and nibble channel out of it.
// ----------------------------------------------------------------------------
interface lcd4_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic [7:0] data_byte;
  logic       is_display_data;
  logic       bottom_line;

  modport source (output valid, req_type, data_byte, is_display_data, bottom_line,
                  input ready);
  modport sink (input valid, req_type, data_byte, is_display_data, bottom_line,
                output ready);
endinterface

interface lcd4_nib_if;
  logic        valid;
  logic        ready;
  logic        reg_select;
  logic [3:0]  nibble;
  logic [14:0] wait_before_us;
  logic [12:0] wait_after_us;
  logic        last_nibble;

  modport source (output valid, reg_select, nibble, wait_before_us, wait_after_us,
                  last_nibble, input ready);
  modport sink (input valid, reg_select, nibble, wait_before_us, wait_after_us,
                last_nibble, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/lcd4_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// lcd4_front
// Accepts requests, turns each into a job descriptor and holds it in a small
// queue until the back end takes it.
// ----------------------------------------------------------------------------
module lcd4_front #(
  parameter int unsigned QueueDepth = lcd4_pkg::QUEUE_DEPTH
) (
  input  wire               clk_i,
  input  wire               rst_ni,
  lcd4_req_if.sink          req_i,
  output logic              q_valid_o,
  output lcd4_pkg::desc_t   q_desc_o,
  input  wire               q_pop_i
);
  import lcd4_pkg::*;

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(QueueDepth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(QueueDepth);

  desc_t           mem_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  desc_t           desc;
  logic            push, pop;

  // classify
  always_comb begin
    desc.is_init   = 1'b0;
    desc.rs        = 1'b0;
    desc.cmd_byte  = CMD_CLEAR;
    desc.low_after = CLEAR_GAP_US;
    case (req_type_e'(req_i.req_type))
      REQ_INIT: begin
        desc.is_init = 1'b1;
      end
      REQ_WRITE: begin
        desc.rs        = req_i.is_display_data;
        desc.cmd_byte  = req_i.data_byte;
        desc.low_after = req_i.is_display_data ? LO_GAP_EXTRA_US : LO_GAP_US;
      end
      REQ_SET_LINE: begin
        desc.cmd_byte  = req_i.bottom_line ? CMD_BOTTOM_LINE : CMD_TOP_LINE;
        desc.low_after = LO_GAP_EXTRA_US;
      end
      REQ_CLEAR: begin
        desc.cmd_byte  = CMD_CLEAR;
        desc.low_after = CLEAR_GAP_US;
      end
      default: begin
        desc.cmd_byte  = CMD_CLEAR;
        desc.low_after = CLEAR_GAP_US;
      end
    endcase
  end

  assign req_i.ready = (cnt_q != FullCnt);
  assign push        = req_i.valid && req_i.ready;
  assign q_valid_o   = (cnt_q != '0);
  assign pop         = q_pop_i && q_valid_o;
  assign q_desc_o    = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= desc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (pop && !push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= FullCnt) else $error("queue count over depth");
  a_full_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == FullCnt && !pop) |=> cnt_q == FullCnt) else $error("full queue lost entry");
  a_empty_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0 && !push) |=> cnt_q == '0) else $error("empty queue gained entry");
`endif

endmodule
`default_nettype wire

@@ hw/rtl/lcd4_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// lcd4_back
// Takes job descriptors from the queue and steps through their nibble
// transfers, one per cycle unless nib_o stalls, into an output register.
// ----------------------------------------------------------------------------
module lcd4_back (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               q_valid_i,
  input  lcd4_pkg::desc_t   q_desc_i,
  output logic              q_pop_o,
  lcd4_nib_if.source        nib_o
);
  import lcd4_pkg::*;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_e;

  state_e              state_q;
  desc_t               desc_q;
  logic [STEP_W-1:0]   step_q;
  logic                out_valid_q;
  logic                out_rs_q;
  logic [NIB_W-1:0]    out_nib_q;
  logic [BEFORE_W-1:0] out_before_q;
  logic [AFTER_W-1:0]  out_after_q;
  logic                out_last_q;

  nib_xfer_t           cur;
  logic                cur_last;
  logic                adv;
  logic                load;

  always_comb begin
    if (desc_q.is_init) begin
      cur      = init_step(step_q);
      cur_last = (step_q == INIT_LAST_STEP);
    end else begin
      cur.pre_wait = '0;
      cur_last     = (step_q == BYTE_LAST_STEP);
      if (step_q == '0) begin
        cur.nib   = desc_q.cmd_byte[7:4];
        cur.after = HI_GAP_US;
      end else begin
        cur.nib   = desc_q.cmd_byte[3:0];
        cur.after = desc_q.low_after;
      end
    end
  end

  assign adv     = (state_q == ST_RUN) && (!out_valid_q || nib_o.ready);
  assign q_pop_o = (state_q == ST_IDLE) || (adv && cur_last);
  assign load    = q_pop_o && q_valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      desc_q       <= '0;
      step_q       <= '0;
      out_valid_q  <= 1'b0;
      out_rs_q     <= 1'b0;
      out_nib_q    <= '0;
      out_before_q <= '0;
      out_after_q  <= '0;
      out_last_q   <= 1'b0;
    end else begin
      if (load) begin
        state_q <= ST_RUN;
        desc_q  <= q_desc_i;
        step_q  <= '0;
      end else if (adv && cur_last) begin
        state_q <= ST_IDLE;
        step_q  <= '0;
      end else if (adv) begin
        step_q <= step_q + STEP_W'(1);
      end
      if (adv) begin
        out_valid_q  <= 1'b1;
        out_rs_q     <= desc_q.rs;
        out_nib_q    <= cur.nib;
        out_before_q <= cur.pre_wait;
        out_after_q  <= cur.after;
        out_last_q   <= cur_last;
      end else if (nib_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign nib_o.valid          = out_valid_q;
  assign nib_o.reg_select     = out_rs_q;
  assign nib_o.nibble         = out_nib_q;
  assign nib_o.wait_before_us = out_before_q;
  assign nib_o.wait_after_us  = out_after_q;
  assign nib_o.last_nibble    = out_last_q;

`ifndef SYNTHESIS
  a_byte_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN && !desc_q.is_init) |-> step_q <= BYTE_LAST_STEP)
    else $error("byte run past its low nibble");
  a_init_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN && desc_q.is_init) |-> step_q <= INIT_LAST_STEP)
    else $error("init run past its last nibble");
  a_step_inc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && !cur_last) |=> (step_q == $past(step_q) + STEP_W'(1)))
    else $error("step did not advance");
  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && cur_last && !q_valid_i) |=> state_q == ST_IDLE)
    else $error("run did not end on last nibble");
`endif

endmodule
`default_nettype wire

@@ hw/rtl/char_lcd_4bit_nibble_sequencer.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// char_lcd_4bit_nibble_sequencer
// Turns character LCD requests into nibble transfers for a 4-bit bus.
//
//   channel  dir  payload
//   req_i    in   req_type, data_byte, is_display_data, bottom_line
//   nib_o    out  reg_select, nibble, wait_before_us, wait_after_us,
//                 last_nibble
//
// an init request yields 14 nibbles, any other request 2, one nibble per
// cycle from the back end step counter unless nib_o stalls; a queued request
// is loaded as the last nibble of the previous one is registered.
// reset empties the queue and idles the sequencer; no clearing pass.
// a stall on nib_o holds the sequencer; the queue keeps taking requests
// until it is full.
// ----------------------------------------------------------------------------
module char_lcd_4bit_nibble_sequencer #(
  parameter int unsigned QueueDepth = lcd4_pkg::QUEUE_DEPTH
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  lcd4_req_if.sink    req_i,
  lcd4_nib_if.source  nib_o
);
  import lcd4_pkg::*;

  logic  q_valid;
  desc_t q_desc;
  logic  q_pop;

  lcd4_front #(
    .QueueDepth (QueueDepth)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (req_i),
    .q_valid_o (q_valid),
    .q_desc_o  (q_desc),
    .q_pop_i   (q_pop)
  );

  lcd4_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_desc_i  (q_desc),
    .q_pop_o   (q_pop),
    .nib_o     (nib_o)
  );

endmodule
`default_nettype wire

@@ bench/char_lcd_4bit_nibble_sequencer_test.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// char_lcd_4bit_nibble_sequencer_test
// Self-checking bench for the LCD nibble sequencer. Requests go in on the
// request channel. Every nibble transfer that comes out is compared field by
// field with a queue of expected transfers, filled from the table where a row
// gives them, else by a behavioral model of the init run, writes, set line, clear.
// A short table of directed requests comes first, then random requests.
// Random stalls are put on both channels in two of three phases, and the
// sender waits for the output to drain at the end of each phase.
// ----------------------------------------------------------------------------
module char_lcd_4bit_nibble_sequencer_test;
  import lcd4_pkg::*;

  typedef struct packed {
    logic                reg_select;
    logic [NIB_W-1:0]    nibble;
    logic [BEFORE_W-1:0] wait_before_us;
    logic [AFTER_W-1:0]  wait_after_us;
    logic                last_nibble;
  } lcd_nibble_t;

  typedef struct packed {
    req_type_e          kind;
    logic [BYTE_W-1:0]  data_byte;
    logic               is_display_data;
    logic               bottom_line;
    logic               typed;
    logic               rs;
    logic [NIB_W-1:0]   hi_nib;
    logic [NIB_W-1:0]   lo_nib;
    logic [AFTER_W-1:0] lo_gap;
  } stim_row_t;

  localparam logic [NIB_W-1:0]   WAKE_NIBS [4] = '{4'h3, 4'h3, 4'h3, 4'h2};
  localparam logic [AFTER_W-1:0] WAKE_GAPS [4] = '{13'd5005, 13'd205, 13'd55, 13'd55};
  localparam logic [BYTE_W-1:0]  INIT_CMDS [5] = '{8'h28, 8'h08, 8'h01, 8'h06, 8'h0E};

  localparam int NUM_ROWS = 18;
  localparam stim_row_t STIM_TABLE [NUM_ROWS] = '{
    '{REQ_INIT,     8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 4'h0, 4'h0, 13'd0},
    '{REQ_WRITE,    8'h00, 1'b0, 1'b0, 1'b1, 1'b0, 4'h0, 4'h0, 13'd55},
    '{REQ_WRITE,    8'hFF, 1'b1, 1'b1, 1'b1, 1'b1, 4'hF, 4'hF, 13'd105},
    '{REQ_WRITE,    8'hFF, 1'b0, 1'b1, 1'b1, 1'b0, 4'hF, 4'hF, 13'd55},
    '{REQ_WRITE,    8'h00, 1'b1, 1'b0, 1'b1, 1'b1, 4'h0, 4'h0, 13'd105},
    '{REQ_SET_LINE, 8'hFF, 1'b1, 1'b0, 1'b1, 1'b0, 4'h8, 4'h0, 13'd105},
    '{REQ_SET_LINE, 8'h00, 1'b0, 1'b1, 1'b1, 1'b0, 4'hC, 4'h0, 13'd105},
    '{REQ_CLEAR,    8'hA5, 1'b1, 1'b1, 1'b1, 1'b0, 4'h0, 4'h1, 13'd5055},
    '{REQ_CLEAR,    8'h00, 1'b0, 1'b0, 1'b1, 1'b0, 4'h0, 4'h1, 13'd5055},
    '{REQ_INIT,     8'hFF, 1'b1, 1'b1, 1'b0, 1'b0, 4'h0, 4'h0, 13'd0},
    '{REQ_WRITE,    8'hA5, 1'b1, 1'b1, 1'b0, 1'b0, 4'h0, 4'h0, 13'd0},
    '{REQ_WRITE,    8'h5A, 1'b0, 1'b0, 1'b0, 1'b0, 4'h0, 4'h0, 13'd0},
    '{REQ_WRITE,    8'h80, 1'b1, 1'b0, 1'b0, 1'b0, 4'h0, 4'h0, 13'd0},
    '{REQ_WRITE,    8'h01, 1'b0, 1'b1, 1'b0, 1'b0, 4'h0, 4'h0, 13'd0},
    '{REQ_SET_LINE, 8'h5A, 1'b0, 1'b1, 1'b0, 1'b0, 4'h0, 4'h0, 13'd0},
    '{REQ_CLEAR,    8'h7F, 1'b0, 1'b0, 1'b0, 1'b0, 4'h0, 4'h0, 13'd0},
    '{REQ_INIT,     8'h3C, 1'b0, 1'b1, 1'b0, 1'b0, 4'h0, 4'h0, 13'd0},
    '{REQ_WRITE,    8'h7F, 1'b1, 1'b0, 1'b0, 1'b0, 4'h0, 4'h0, 13'd0}
  };

  logic clk_i;
  logic rst_ni;

  lcd4_req_if req_ch ();
  lcd4_nib_if nib_ch ();

  char_lcd_4bit_nibble_sequencer DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_ch),
    .nib_o  (nib_ch)
  );

  lcd_nibble_t pending_nibbles[$];
  int          send_idle_pct;
  int          recv_idle_pct;
  int          error_count;
  int          nibbles_checked;
  int          req_count[4];

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #1000000;
    $display("timeout: %0d nibbles still expected", pending_nibbles.size());
    $display("CHECKS FAILED");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    error_count++;
    if (error_count <= 40) $display("[%0t] mismatch: %s", $time, msg);
  endtask

  function automatic void queue_nibble(input logic rs, input logic [NIB_W-1:0] nib,
                                       input logic [BEFORE_W-1:0] pre_wait,
                                       input logic [AFTER_W-1:0] after);
    lcd_nibble_t n;
    n.reg_select     = rs;
    n.nibble         = nib;
    n.wait_before_us = pre_wait;
    n.wait_after_us  = after;
    n.last_nibble    = 1'b0;
    pending_nibbles.push_back(n);
  endfunction

  function automatic void queue_byte(input logic rs, input logic [BYTE_W-1:0] b,
                                     input logic [AFTER_W-1:0] lo_gap);
    queue_nibble(rs, b[7:4], 15'd0, HI_GAP_US);
    queue_nibble(rs, b[3:0], 15'd0, lo_gap);
  endfunction

  function automatic void predict_nibble_run(input req_type_e kind,
                                             input logic [BYTE_W-1:0] data,
                                             input logic disp, input logic bottom);
    int i;
    case (kind)
      REQ_INIT: begin
        for (i = 0; i < 4; i++)
          queue_nibble(1'b0, WAKE_NIBS[i], (i == 0) ? POWERUP_WAIT_US : 15'd0,
                       WAKE_GAPS[i]);
        for (i = 0; i < 5; i++)
          queue_byte(1'b0, INIT_CMDS[i],
                     (INIT_CMDS[i] == CMD_CLEAR) ? CLEAR_GAP_US : LO_GAP_EXTRA_US);
      end
      REQ_WRITE: begin
        queue_byte(disp, data, disp ? LO_GAP_EXTRA_US : LO_GAP_US);
      end
      REQ_SET_LINE: begin
        queue_byte(1'b0, bottom ? CMD_BOTTOM_LINE : CMD_TOP_LINE, LO_GAP_EXTRA_US);
      end
      default: begin
        queue_byte(1'b0, CMD_CLEAR, CLEAR_GAP_US);
      end
    endcase
    pending_nibbles[pending_nibbles.size()-1].last_nibble = 1'b1;
  endfunction

  // returns at the edge where the request is taken
  task automatic send_request(input req_type_e kind, input logic [BYTE_W-1:0] data,
                              input logic disp, input logic bottom);
    while ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_ch.valid           <= 1'b1;
    req_ch.req_type        <= kind;
    req_ch.data_byte       <= data;
    req_ch.is_display_data <= disp;
    req_ch.bottom_line     <= bottom;
    do @(posedge clk_i); while (!(req_ch.valid && req_ch.ready));
    req_count[kind]++;
  endtask

  always @(posedge clk_i) begin
    lcd_nibble_t want;
    if (rst_ni && nib_ch.valid && nib_ch.ready) begin
      if (pending_nibbles.size() == 0) begin
        report_mismatch($sformatf("nibble %h with no request pending", nib_ch.nibble));
      end else begin
        want = pending_nibbles.pop_front();
        nibbles_checked++;
        if (nib_ch.reg_select !== want.reg_select)
          report_mismatch($sformatf("reg_select %b, want %b",
                                    nib_ch.reg_select, want.reg_select));
        if (nib_ch.nibble !== want.nibble)
          report_mismatch($sformatf("nibble %h, want %h", nib_ch.nibble, want.nibble));
        if (nib_ch.wait_before_us !== want.wait_before_us)
          report_mismatch($sformatf("wait_before_us %0d, want %0d",
                                    nib_ch.wait_before_us, want.wait_before_us));
        if (nib_ch.wait_after_us !== want.wait_after_us)
          report_mismatch($sformatf("wait_after_us %0d, want %0d",
                                    nib_ch.wait_after_us, want.wait_after_us));
        if (nib_ch.last_nibble !== want.last_nibble)
          report_mismatch($sformatf("last_nibble %b, want %b",
                                    nib_ch.last_nibble, want.last_nibble));
      end
    end
    nib_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  initial begin
    int          phase;
    int          r;
    stim_row_t   row;
    req_type_e   kind;
    logic [7:0]  data;
    logic        disp;
    logic        bottom;

    error_count     = 0;
    nibbles_checked = 0;
    send_idle_pct   = 33;
    recv_idle_pct   = 51;
    foreach (req_count[i]) req_count[i] = 0;

    rst_ni                 <= 1'b0;
    req_ch.valid           <= 1'b0;
    req_ch.req_type        <= REQ_INIT;
    req_ch.data_byte       <= '0;
    req_ch.is_display_data <= 1'b0;
    req_ch.bottom_line     <= 1'b0;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 33;
          recv_idle_pct = 51;
        end
        1: begin
          send_idle_pct = 51;
          recv_idle_pct = 33;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase

      if (phase == 0) begin
        for (r = 0; r < NUM_ROWS; r++) begin
          row = STIM_TABLE[r];
          send_request(row.kind, row.data_byte, row.is_display_data, row.bottom_line);
          if (row.typed) begin
            queue_nibble(row.rs, row.hi_nib, 15'd0, 13'd15);
            queue_nibble(row.rs, row.lo_nib, 15'd0, row.lo_gap);
            pending_nibbles[pending_nibbles.size()-1].last_nibble = 1'b1;
          end else begin
            predict_nibble_run(row.kind, row.data_byte, row.is_display_data,
                               row.bottom_line);
          end
        end
      end

      repeat ((phase == 0) ? 30 : 40) begin
        kind   = req_type_e'($urandom_range(3));
        data   = 8'($urandom_range(255));
        disp   = 1'($urandom_range(1));
        bottom = 1'($urandom_range(1));
        send_request(kind, data, disp, bottom);
        predict_nibble_run(kind, data, disp, bottom);
      end

      // hold off new requests until the output has drained
      req_ch.valid <= 1'b0;
      do @(posedge clk_i); while (pending_nibbles.size() != 0);
    end

    repeat (20) @(posedge clk_i);

    $display("covered %0d init, %0d write, %0d set line, %0d clear requests",
             req_count[REQ_INIT], req_count[REQ_WRITE], req_count[REQ_SET_LINE],
             req_count[REQ_CLEAR]);
    $display("%0d nibble transfers checked under three stall patterns, %0d mismatches",
             nibbles_checked, error_count);
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire
